FILE: rtl/assert_macros.svh
// assertion helpers for the scheduler checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/rts_pkg.sv
// ----------------------------------------------------------------------------
// rts_pkg
// types and codes shared by the task scheduler modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rts_pkg;

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_LOCK    = 3'd1;
    localparam logic [2:0] CMD_EXPIRE  = 3'd2;
    localparam logic [2:0] CMD_WORD    = 3'd3;
    localparam logic [2:0] CMD_FILL    = 3'd4;
    localparam logic [2:0] CMD_SCHED   = 3'd5;
    localparam logic [2:0] CMD_PREEMPT = 3'd6;
    localparam logic [2:0] CMD_RSVD    = 3'd7;

    localparam logic [2:0] MODE_RUN    = 3'd0;
    localparam logic [2:0] MODE_SUSP   = 3'd1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EXPIRED  = 2'd1;
    localparam logic [1:0] ST_REJECT   = 2'd2;

    localparam logic [1:0] KIND_MUTEX  = 2'd0;
    localparam logic [1:0] KIND_EVENT  = 2'd1;
    localparam logic [1:0] KIND_QFULL  = 2'd2;
    localparam logic [1:0] KIND_QEMPTY = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  task_slot;
        logic [3:0]  priority_req;
        logic [1:0]  lock_kind;
        logic [2:0]  object_index;
        logic [31:0] bit_mask;
        logic [31:0] word_value;
        logic [15:0] fill_count;
        logic [15:0] queue_size;
    } rts_in_t;

    typedef struct packed {
        logic [2:0] current_task;
        logic       is_idle;
        logic [1:0] status;
    } rts_out_t;

    // condition evaluation request to the shared compare unit
    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] word;
        logic [31:0] mask;
        logic [15:0] fill;
        logic [15:0] cap;
    } rts_cond_t;

endpackage

FILE: rtl/rts_cond_unit.sv
// ----------------------------------------------------------------------------
// rts_cond_unit
// shared lock condition test, one task per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rts_cond_unit
    import rts_pkg::*;
(
    input  rts_cond_t req,
    output logic      met
);

    logic [31:0] masked;

    assign masked = req.word & req.mask;

    always_comb
    begin
        met = 1'b0;
        if (req.mode[2])
        begin
            unique case (req.mode[1:0])
                KIND_MUTEX:  met = (masked == 32'd0);
                KIND_EVENT:  met = (masked != 32'd0);
                KIND_QFULL:  met = (req.fill < req.cap);
                KIND_QEMPTY: met = (req.fill != 16'd0);
                default:     met = 1'b0;
            endcase
        end
    end

endmodule

FILE: rtl/rtos_task_scheduler.sv
// ----------------------------------------------------------------------------
// rtos_task_scheduler
// priority round-robin task scheduler with a sequenced queue scan
// ----------------------------------------------------------------------------
// channel  direction  handshake         payload
// in       to block   in_valid/in_stall rts_in_t
// out      from block out_valid/out_stall rts_out_t
// cfg      to block   cfg_we            use_priority
// simple commands pass through the decode and output states before their result is offered
// schedule, lock and preempt walk the queue one slot a cycle: the preempt check
// (preempt only, through the shared compare unit), move to tail, the selection
// scan (through the shared compare unit) and then apply
// reset returns the state to an empty queue with the idle task running
// a stalled result holds; no new transfer is taken until it has gone
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtos_task_scheduler
    import rts_pkg::*;
#(
    parameter int NUM_TASKS   = 8,
    parameter int NUM_OBJECTS = 8,
    parameter int PRIO_BITS   = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  rts_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output rts_out_t out_data,
    input  logic     cfg_we,
    input  logic     cfg_wdata
);

    localparam int TW = $clog2(NUM_TASKS);
    localparam int OW = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam int LW = $clog2(NUM_TASKS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010,
        S_TAIL  = 7'b0000100,
        S_PCHK  = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_APPLY = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]           order_reg [NUM_TASKS];
    logic [LW-1:0]        qlen_reg;
    logic [2:0]           mode_reg [NUM_TASKS];
    logic [PRIO_BITS-1:0] prio_reg [NUM_TASKS];
    logic [31:0]          tmask_reg [NUM_TASKS];
    logic [2:0]           tobj_reg [NUM_TASKS];
    logic [NUM_TASKS-1:0] exp_reg;
    logic [31:0]          oword_reg [NUM_OBJECTS];
    logic [15:0]          ofill_reg [NUM_OBJECTS];
    logic [15:0]          ocap_reg [NUM_OBJECTS];
    logic [2:0]           run_reg;
    logic                 idle_reg;
    logic                 usep_reg;

    rts_in_t              cmd_reg;
    logic [LW-1:0]        idx_reg;
    logic                 found_reg;
    logic                 rdy_v_reg, sus_v_reg;
    logic [2:0]           rdy_reg, sus_reg;
    logic [1:0]           st_reg;
    rts_out_t             out_reg;
    logic                 ov_reg;

    logic [2:0]  cur_t;
    logic [OW-1:0] cur_o;
    logic        met;
    rts_cond_t   creq;
    logic        inq;
    logic        slot_ok, obj_ok;
    logic [TW-1:0] idx_t;

    assign idx_t = idx_reg[TW-1:0];
    assign cur_t = order_reg[idx_t];
    assign cur_o = (OW)'(tobj_reg[(TW)'(cur_t)]);

    always_comb
    begin
        creq.mode = mode_reg[(TW)'(cur_t)];
        creq.mask = tmask_reg[(TW)'(cur_t)];
        creq.word = oword_reg[cur_o];
        creq.fill = ofill_reg[cur_o];
        creq.cap  = ocap_reg[cur_o];
    end

    rts_cond_unit u_cond (.req(creq), .met(met));

    assign slot_ok = (int'(cmd_reg.task_slot) < NUM_TASKS);
    assign obj_ok  = (int'(cmd_reg.object_index) < NUM_OBJECTS);

    always_comb
    begin
        inq = 1'b0;
        for (int i = 0; i < NUM_TASKS; i++)
            if ((LW)'(i) < qlen_reg && order_reg[i] == cmd_reg.task_slot)
                inq = 1'b1;
    end

    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            usep_reg <= 1'b1;
        else if (cfg_we)
            usep_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            qlen_reg  <= '0;
            exp_reg   <= '0;
            run_reg   <= '0;
            idle_reg  <= 1'b1;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            rdy_v_reg <= 1'b0;
            sus_v_reg <= 1'b0;
            rdy_reg   <= '0;
            sus_reg   <= '0;
            st_reg    <= ST_OK;
            cmd_reg   <= '0;
            out_reg   <= '0;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                order_reg[i] <= '0;
                mode_reg[i]  <= MODE_RUN;
                prio_reg[i]  <= '0;
                tmask_reg[i] <= '0;
                tobj_reg[i]  <= '0;
            end
            for (int j = 0; j < NUM_OBJECTS; j++)
            begin
                oword_reg[j] <= '0;
                ofill_reg[j] <= '0;
                ocap_reg[j]  <= '0;
            end
        end
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        cmd_reg   <= in_data;
                        st_reg    <= ST_OK;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_OUT;
                    unique case (cmd_reg.cmd)
                        CMD_ADD:
                        begin
                            if (!slot_ok || inq || qlen_reg >= (LW)'(NUM_TASKS))
                                st_reg <= ST_REJECT;
                            else
                            begin
                                order_reg[qlen_reg[TW-1:0]] <= cmd_reg.task_slot;
                                qlen_reg <= qlen_reg + 1'b1;
                                mode_reg[(TW)'(cmd_reg.task_slot)] <= MODE_RUN;
                                prio_reg[(TW)'(cmd_reg.task_slot)] <=
                                    (PRIO_BITS)'(cmd_reg.priority_req);
                                exp_reg[(TW)'(cmd_reg.task_slot)] <= 1'b0;
                            end
                        end
                        CMD_LOCK:
                        begin
                            if (idle_reg || !obj_ok)
                                st_reg <= ST_REJECT;
                            else if (exp_reg[(TW)'(run_reg)])
                            begin
                                exp_reg[(TW)'(run_reg)] <= 1'b0;
                                st_reg <= ST_EXPIRED;
                            end
                            else
                            begin
                                mode_reg[(TW)'(run_reg)]  <= {1'b1, cmd_reg.lock_kind};
                                tobj_reg[(TW)'(run_reg)]  <= cmd_reg.object_index;
                                tmask_reg[(TW)'(run_reg)] <= cmd_reg.bit_mask;
                                state_reg <= S_TAIL;
                            end
                        end
                        CMD_EXPIRE:
                        begin
                            if (!slot_ok || !inq)
                                st_reg <= ST_REJECT;
                            else
                                exp_reg[(TW)'(cmd_reg.task_slot)] <= 1'b1;
                        end
                        CMD_WORD:
                        begin
                            if (!obj_ok)
                                st_reg <= ST_REJECT;
                            else
                                oword_reg[(OW)'(cmd_reg.object_index)] <=
                                    cmd_reg.word_value;
                        end
                        CMD_FILL:
                        begin
                            if (!obj_ok)
                                st_reg <= ST_REJECT;
                            else
                            begin
                                ofill_reg[(OW)'(cmd_reg.object_index)] <=
                                    cmd_reg.fill_count;
                                ocap_reg[(OW)'(cmd_reg.object_index)] <=
                                    cmd_reg.queue_size;
                            end
                        end
                        CMD_SCHED:
                            state_reg <= S_TAIL;
                        CMD_PREEMPT:
                        begin
                            if (idle_reg)
                                state_reg <= S_TAIL;
                            else if (mode_reg[(TW)'(run_reg)] != MODE_RUN)
                                state_reg <= S_OUT;
                            else if (!usep_reg)
                            begin
                                mode_reg[(TW)'(run_reg)] <= MODE_SUSP;
                                state_reg <= S_TAIL;
                            end
                            else
                                state_reg <= S_PCHK;
                        end
                        default:
                            st_reg <= ST_REJECT;
                    endcase
                end
                S_PCHK:
                begin
                    // look for a suspended or released task of no lower priority
                    if (idx_reg >= qlen_reg)
                        state_reg <= S_OUT;
                    else if (cur_t != run_reg &&
                             (mode_reg[(TW)'(cur_t)] == MODE_SUSP || met) &&
                             prio_reg[(TW)'(cur_t)] <= prio_reg[(TW)'(run_reg)])
                    begin
                        mode_reg[(TW)'(run_reg)] <= MODE_SUSP;
                        idx_reg   <= '0;
                        state_reg <= S_TAIL;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_TAIL:
                begin
                    // bubble the running slot to the end, one swap a cycle
                    if (idle_reg || idx_reg + 1'b1 >= qlen_reg)
                    begin
                        idx_reg   <= '0;
                        rdy_v_reg <= 1'b0;
                        sus_v_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        if (found_reg || cur_t == run_reg)
                        begin
                            found_reg <= 1'b1;
                            order_reg[idx_t] <= order_reg[idx_t + 1'b1];
                            order_reg[idx_t + 1'b1] <= cur_t;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg >= qlen_reg || (rdy_v_reg && !usep_reg))
                        state_reg <= S_APPLY;
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (!mode_reg[(TW)'(cur_t)][2])
                        begin
                            if (!sus_v_reg)
                            begin
                                sus_v_reg <= 1'b1;
                                sus_reg   <= cur_t;
                            end
                        end
                        else if (exp_reg[(TW)'(cur_t)] || met)
                        begin
                            if (!rdy_v_reg ||
                                prio_reg[(TW)'(cur_t)] < prio_reg[(TW)'(rdy_reg)])
                            begin
                                rdy_v_reg <= 1'b1;
                                rdy_reg   <= cur_t;
                            end
                        end
                    end
                end
                S_APPLY:
                begin
                    state_reg <= S_OUT;
                    if (rdy_v_reg)
                    begin
                        mode_reg[(TW)'(rdy_reg)] <= MODE_RUN;
                        exp_reg[(TW)'(rdy_reg)]  <= 1'b0;
                        run_reg  <= rdy_reg;
                        idle_reg <= 1'b0;
                    end
                    else if (sus_v_reg)
                    begin
                        mode_reg[(TW)'(sus_reg)] <= MODE_RUN;
                        run_reg  <= sus_reg;
                        idle_reg <= 1'b0;
                    end
                    else
                    begin
                        run_reg  <= '0;
                        idle_reg <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    out_reg.current_task <= idle_reg ? 3'd0 : run_reg;
                    out_reg.is_idle      <= idle_reg;
                    out_reg.status       <= st_reg;
                    ov_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/rts_checker.sv
// ----------------------------------------------------------------------------
// rts_checker
// port level checks on the task scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rts_checker
    import rts_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input rts_out_t out_data
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `ASSERT_IMPL(a_idle_slot, clk, rst_n, out_valid && out_data.is_idle, out_data.current_task == 3'd0)
    `ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_data.status != 2'd3)
    `ASSERT_NEXT(a_busy_after, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

bind rtos_task_scheduler rts_checker u_rts_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
